/* hdl/lswc_pkg.sv */
package lswc_pkg;

    // Number of endpoint moves the chain can make before a segment is given up.
    localparam int unsigned CLIP_STAGES = 4;

    // Region code bits, highest first: above, below, right, left.
    localparam int unsigned CODE_BITS  = 4;
    localparam int unsigned BIT_ABOVE  = 3;
    localparam int unsigned BIT_BELOW  = 2;
    localparam int unsigned BIT_RIGHT  = 1;
    localparam int unsigned BIT_LEFT   = 0;

    typedef logic [CODE_BITS-1:0] region_code_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_Y_MIN = 2'd1,
        REG_X_MAX = 2'd2,
        REG_Y_MAX = 2'd3
    } cfg_reg_t;

    // Clip cell sequencer.
    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_EVAL,
        CELL_DIV,
        CELL_WB,
        CELL_FULL
    } cell_state_t;

    // Outcome travelling with a segment along the chain.
    typedef struct packed {
        logic resolved;
        logic visible;
    } seg_status_t;

endpackage

/* hdl/line_segment_window_clipper.sv */
// Line segment window clipper (Cohen-Sutherland).
// A request on the s_ channel carries one segment: start_x, start_y, end_x,
// end_y packed in s_tdata. One result request leaves on the m_ channel for
// each segment: the clipped endpoints in m_tdata and the visible flag in
// m_tuser. A rejected segment comes out with visible low and zero endpoints.
// The window is set through the write port (cfg_wr_en, cfg_index,
// cfg_data); it should only be changed while no segment is in flight.
// The segment walks through a row of CLIP_STAGES identical clip cells. A
// cell that finds the segment unresolved moves one outside endpoint onto a
// window edge, using one multiplier and a restoring divider that retires one
// quotient bit per cycle. Each cell holds one segment and returns to idle
// after handing it on, so it takes no new segment until the last has left.
// A stalled receiver makes the output register hold its result and
// back-pressure runs up the row to s_tready.
// Reset is synchronous and active low: all cells empty, the window returns
// to 0..499 on both axes.
module line_segment_window_clipper #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  lswc_pkg::cfg_reg_t                      cfg_index,
    input  logic [COORD_WIDTH-1:0]                  cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, padded
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
    // visible
    output logic                                    m_tuser
);
    import lswc_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int TDW  = ((4*COORD_WIDTH+7)/8)*8;
    localparam int PADW = TDW - 4*COORD_WIDTH;

    logic signed [W-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= '0;
            y_min_reg <= '0;
            x_max_reg <= W'(499);
            y_max_reg <= W'(499);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_X_MIN: x_min_reg <= cfg_data;
                REG_Y_MIN: y_min_reg <= cfg_data;
                REG_X_MAX: x_max_reg <= cfg_data;
                REG_Y_MAX: y_max_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Link i feeds cell i; link CLIP_STAGES feeds the output stage.
    logic                vld [CLIP_STAGES+1];
    logic                rdy [CLIP_STAGES+1];
    logic signed [W-1:0] lx0 [CLIP_STAGES+1];
    logic signed [W-1:0] ly0 [CLIP_STAGES+1];
    logic signed [W-1:0] lx1 [CLIP_STAGES+1];
    logic signed [W-1:0] ly1 [CLIP_STAGES+1];
    seg_status_t         lst [CLIP_STAGES+1];

    assign vld[0]   = s_tvalid;
    assign s_tready = rdy[0];
    assign lx0[0]   = s_tdata[W-1:0];
    assign ly0[0]   = s_tdata[2*W-1:W];
    assign lx1[0]   = s_tdata[3*W-1:2*W];
    assign ly1[0]   = s_tdata[4*W-1:3*W];
    assign lst[0]   = '{resolved: 1'b0, visible: 1'b0};

    for (genvar i = 0; i < CLIP_STAGES; i++) begin : g_cell
        lswc_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .win_x_min (x_min_reg),
            .win_y_min (y_min_reg),
            .win_x_max (x_max_reg),
            .win_y_max (y_max_reg),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_x0     (lx0[i]),
            .in_y0     (ly0[i]),
            .in_x1     (lx1[i]),
            .in_y1     (ly1[i]),
            .in_status (lst[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_x0    (lx0[i+1]),
            .out_y0    (ly0[i+1]),
            .out_x1    (lx1[i+1]),
            .out_y1    (ly1[i+1]),
            .out_status(lst[i+1])
        );
    end

    // Final verdict: a segment still unresolved after the last move is
    // visible only if both endpoints now lie inside the window.
    logic                 fin_inside;
    logic                 fin_vis;
    logic                 m_valid_reg;
    logic                 m_vis_reg;
    logic [4*W-1:0]       m_data_reg;

    always_comb begin
        fin_inside = (lx0[CLIP_STAGES] >= x_min_reg) && (lx0[CLIP_STAGES] <= x_max_reg)
                  && (ly0[CLIP_STAGES] >= y_min_reg) && (ly0[CLIP_STAGES] <= y_max_reg)
                  && (lx1[CLIP_STAGES] >= x_min_reg) && (lx1[CLIP_STAGES] <= x_max_reg)
                  && (ly1[CLIP_STAGES] >= y_min_reg) && (ly1[CLIP_STAGES] <= y_max_reg);
        fin_vis = lst[CLIP_STAGES].resolved ? lst[CLIP_STAGES].visible : fin_inside;
    end

    assign rdy[CLIP_STAGES] = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[CLIP_STAGES]) begin
            m_valid_reg <= vld[CLIP_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[CLIP_STAGES] && vld[CLIP_STAGES]) begin
            m_vis_reg  <= fin_vis;
            m_data_reg <= fin_vis ? {ly1[CLIP_STAGES], lx1[CLIP_STAGES],
                                     ly0[CLIP_STAGES], lx0[CLIP_STAGES]} : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_vis_reg;
    if (PADW > 0) begin : g_pad
        assign m_tdata = {{PADW{1'b0}}, m_data_reg};
    end else begin : g_nopad
        assign m_tdata = m_data_reg;
    end

endmodule

/* hdl/lswc_cell.sv */
module lswc_cell #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [COORD_WIDTH-1:0] win_x_min,
    input  logic signed [COORD_WIDTH-1:0] win_y_min,
    input  logic signed [COORD_WIDTH-1:0] win_x_max,
    input  logic signed [COORD_WIDTH-1:0] win_y_max,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] in_x0,
    input  logic signed [COORD_WIDTH-1:0] in_y0,
    input  logic signed [COORD_WIDTH-1:0] in_x1,
    input  logic signed [COORD_WIDTH-1:0] in_y1,
    input  lswc_pkg::seg_status_t         in_status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x0,
    output logic signed [COORD_WIDTH-1:0] out_y0,
    output logic signed [COORD_WIDTH-1:0] out_x1,
    output logic signed [COORD_WIDTH-1:0] out_y1,
    output lswc_pkg::seg_status_t         out_status
);
    import lswc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int PW    = 2 * COORD_WIDTH;
    localparam int CNT_W = $clog2(PW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

    cell_state_t               st_reg, st_next;
    logic signed [W-1:0]       x0_reg, y0_reg, x1_reg, y1_reg;
    seg_status_t               stat_reg;
    logic                      first_reg;
    logic                      horiz_reg;
    logic signed [W-1:0]       edge_reg;
    logic signed [W-1:0]       base_reg;
    logic                      neg_reg;
    logic                      zden_reg;
    logic [W-1:0]              den_reg;
    logic [PW-1:0]             div_reg;
    logic [W-1:0]              rem_reg;
    logic [W-1:0]              quo_reg;
    logic [CNT_W-1:0]          cnt_reg;

    region_code_t              c0, c1, csel;
    logic signed [W-1:0]       e_val, a_val, p_lo, p_hi;
    logic signed [W:0]         d_s, n_s, den_s;
    logic [W-1:0]              d_m, n_m, den_m;
    logic [W:0]                rem_w, rem_sub;
    logic                      q_bit;
    logic signed [W:0]         moved;
    logic [W-1:0]              q_eff;

    function automatic region_code_t region(
        input logic signed [W-1:0] x, input logic signed [W-1:0] y,
        input logic signed [W-1:0] xl, input logic signed [W-1:0] yl,
        input logic signed [W-1:0] xh, input logic signed [W-1:0] yh);
        region_code_t c;
        c = '0;
        c[BIT_ABOVE] = (y > yh);
        c[BIT_BELOW] = (y < yl);
        c[BIT_RIGHT] = (x > xh);
        c[BIT_LEFT]  = (x < xl);
        return c;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W:0] v);
        logic signed [W:0] a;
        a = v[W] ? -v : v;
        return a[W-1:0];
    endfunction

    always_comb begin
        c0   = region(x0_reg, y0_reg, win_x_min, win_y_min, win_x_max, win_y_max);
        c1   = region(x1_reg, y1_reg, win_x_min, win_y_min, win_x_max, win_y_max);
        csel = (c0 != '0) ? c0 : c1;
        priority if (csel[BIT_ABOVE]) begin
            e_val = win_y_max;
        end else if (csel[BIT_BELOW]) begin
            e_val = win_y_min;
        end else if (csel[BIT_RIGHT]) begin
            e_val = win_x_max;
        end else begin
            e_val = win_x_min;
        end
        // Horizontal edge: interpolate x over y; vertical edge: y over x.
        if (csel[BIT_ABOVE] || csel[BIT_BELOW]) begin
            a_val = x0_reg;
            p_lo  = y0_reg;
            p_hi  = y1_reg;
            d_s   = {x1_reg[W-1], x1_reg} - {x0_reg[W-1], x0_reg};
        end else begin
            a_val = y0_reg;
            p_lo  = x0_reg;
            p_hi  = x1_reg;
            d_s   = {y1_reg[W-1], y1_reg} - {y0_reg[W-1], y0_reg};
        end
        n_s   = {e_val[W-1], e_val} - {p_lo[W-1], p_lo};
        den_s = {p_hi[W-1], p_hi} - {p_lo[W-1], p_lo};
        d_m   = mag(d_s);
        n_m   = mag(n_s);
        den_m = mag(den_s);
    end

    // One restoring division step per cycle.
    always_comb begin
        rem_w   = {rem_reg, div_reg[PW-1]};
        rem_sub = rem_w - {1'b0, den_reg};
        q_bit   = (rem_w >= {1'b0, den_reg});
    end

    always_comb begin
        q_eff = zden_reg ? '0 : quo_reg;
        moved = neg_reg ? ({base_reg[W-1], base_reg} - {1'b0, q_eff})
                        : ({base_reg[W-1], base_reg} + {1'b0, q_eff});
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            CELL_IDLE: if (in_valid) st_next = CELL_EVAL;
            CELL_EVAL: begin
                if (stat_reg.resolved || ((c0 | c1) == '0) || ((c0 & c1) != '0)) begin
                    st_next = CELL_FULL;
                end else begin
                    st_next = CELL_DIV;
                end
            end
            CELL_DIV:  if (cnt_reg == '0) st_next = CELL_WB;
            CELL_WB:   st_next = CELL_FULL;
            CELL_FULL: if (out_ready) st_next = CELL_IDLE;
            default:   st_next = CELL_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = (st_reg == CELL_IDLE);
        out_valid  = (st_reg == CELL_FULL);
        out_x0     = x0_reg;
        out_y0     = y0_reg;
        out_x1     = x1_reg;
        out_y1     = y1_reg;
        out_status = stat_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= CELL_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            CELL_IDLE: begin
                x0_reg   <= in_x0;
                y0_reg   <= in_y0;
                x1_reg   <= in_x1;
                y1_reg   <= in_y1;
                stat_reg <= in_status;
            end
            CELL_EVAL: begin
                if (!stat_reg.resolved) begin
                    if ((c0 | c1) == '0) begin
                        stat_reg <= '{resolved: 1'b1, visible: 1'b1};
                    end else if ((c0 & c1) != '0) begin
                        stat_reg <= '{resolved: 1'b1, visible: 1'b0};
                    end
                end
                first_reg <= (c0 != '0);
                horiz_reg <= csel[BIT_ABOVE] || csel[BIT_BELOW];
                edge_reg  <= e_val;
                base_reg  <= a_val;
                neg_reg   <= (d_s[W] != n_s[W]) != den_s[W];
                zden_reg  <= (den_m == '0);
                den_reg   <= den_m;
                div_reg   <= d_m * n_m;
                rem_reg   <= '0;
                quo_reg   <= '0;
                cnt_reg   <= CNT_LAST;
            end
            CELL_DIV: begin
                rem_reg <= q_bit ? rem_sub[W-1:0] : rem_w[W-1:0];
                quo_reg <= {quo_reg[W-2:0], q_bit};
                div_reg <= {div_reg[PW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            CELL_WB: begin
                if (first_reg) begin
                    x0_reg <= horiz_reg ? moved[W-1:0] : edge_reg;
                    y0_reg <= horiz_reg ? edge_reg : moved[W-1:0];
                end else begin
                    x1_reg <= horiz_reg ? moved[W-1:0] : edge_reg;
                    y1_reg <= horiz_reg ? edge_reg : moved[W-1:0];
                end
            end
            default: ;
        endcase
    end

    a_wb_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == CELL_WB) |-> ($past(st_reg) == CELL_DIV))
        else $error("clip cell wrote back without a division");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == CELL_DIV && !zden_reg) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == CELL_FULL && !out_ready) |=>
            ($stable(x0_reg) && $stable(y1_reg) && $stable(stat_reg)))
        else $error("clip cell changed a segment it was still offering");

endmodule

/* sim/tb.sv */
module tb;
    import lswc_pkg::*;

    localparam int CW = 16;
    localparam int DW = ((4*CW+7)/8)*8;

    // One segment as it enters the clipper.
    typedef struct packed {
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x0;
    } segment_t;

    // One clipped result.
    typedef struct {
        logic                 visible;
        logic signed [CW-1:0] x0, y0, x1, y1;
    } clipped_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           cfg_wr_en = 1'b0;
    cfg_reg_t       cfg_index = REG_X_MIN;
    logic [CW-1:0]  cfg_data = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [DW-1:0]  s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [DW-1:0]  m_tdata;
    logic           m_tuser;

    line_segment_window_clipper #(.COORD_WIDTH(CW)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    // Our own copy of the window, as signed integers.
    longint win_xl = 0, win_yl = 0, win_xh = 499, win_yh = 499;

    segment_t pending_segments[$];
    clipped_t expected_clips[$];
    int       mismatch_count = 0;
    int       sender_idle_pct = 0;
    int       receiver_idle_pct = 0;
    int       hold_off_cycles = 0;
    bit       hold_off_go = 1'b0;
    bit       hold_off_done = 1'b0;

    function automatic logic [3:0] region_of(longint x, longint y);
        logic [3:0] c;
        c = '0;
        c[BIT_ABOVE] = y > win_yh;
        c[BIT_BELOW] = y < win_yl;
        c[BIT_RIGHT] = x > win_xh;
        c[BIT_LEFT]  = x < win_xl;
        return c;
    endfunction

    // a + d*num/den, with the quotient truncated toward zero.
    function automatic longint edge_cross(longint a, longint d, longint num, longint den);
        if (den == 0) return a;
        return a + (d * num) / den;
    endfunction

    function automatic clipped_t clip_segment(segment_t sg);
        clipped_t r;
        longint x0, y0, x1, y1, nx, ny;
        logic [3:0] c0, c1, c;
        int stage;
        x0 = sg.x0; y0 = sg.y0; x1 = sg.x1; y1 = sg.y1;
        c0 = region_of(x0, y0);
        c1 = region_of(x1, y1);
        r = '{visible: 1'b0, x0: '0, y0: '0, x1: '0, y1: '0};
        for (stage = 0; ; stage++) begin
            if ((c0 | c1) == 0) begin
                r = '{visible: 1'b1, x0: x0[CW-1:0], y0: y0[CW-1:0],
                      x1: x1[CW-1:0], y1: y1[CW-1:0]};
                break;
            end
            if ((c0 & c1) != 0 || stage >= CLIP_STAGES) break;
            c = (c0 != 0) ? c0 : c1;
            if (c[BIT_ABOVE]) begin
                nx = edge_cross(x0, x1 - x0, win_yh - y0, y1 - y0);
                ny = win_yh;
            end else if (c[BIT_BELOW]) begin
                nx = edge_cross(x0, x1 - x0, win_yl - y0, y1 - y0);
                ny = win_yl;
            end else if (c[BIT_RIGHT]) begin
                ny = edge_cross(y0, y1 - y0, win_xh - x0, x1 - x0);
                nx = win_xh;
            end else begin
                ny = edge_cross(y0, y1 - y0, win_xl - x0, x1 - x0);
                nx = win_xl;
            end
            if (c0 != 0) begin
                x0 = nx; y0 = ny; c0 = region_of(x0, y0);
            end else begin
                x1 = nx; y1 = ny; c1 = region_of(x1, y1);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Driver: presents the next pending segment, predicting its clip when taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_clips.push_back(clip_segment(s_tdata[4*CW-1:0]));
                void'(pending_segments.pop_front());
            end
            if ((!s_tvalid || s_tready) && pending_segments.size() > 0) begin
                if ($urandom_range(99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= DW'(pending_segments[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down in its own process once requested.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (hold_off_go && !hold_off_done) begin
            hold_off_cycles <= 600;
            hold_off_done   <= 1'b1;
        end
    end

    // Monitor: checks each result request against the oldest prediction and
    // sets the ready for the next cycle.
    always @(posedge aclk) begin
        clipped_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_clips.size() == 0) begin
                $display("unexpected result request at %0t", $realtime);
                mismatch_count++;
            end else begin
                want = expected_clips.pop_front();
                if (m_tuser !== want.visible) report_mismatch("visible", m_tuser, want.visible);
                if ($signed(m_tdata[CW-1:0]) !== want.x0)
                    report_mismatch("clipped_start_x", $signed(m_tdata[CW-1:0]), want.x0);
                if ($signed(m_tdata[2*CW-1:CW]) !== want.y0)
                    report_mismatch("clipped_start_y", $signed(m_tdata[2*CW-1:CW]), want.y0);
                if ($signed(m_tdata[3*CW-1:2*CW]) !== want.x1)
                    report_mismatch("clipped_end_x", $signed(m_tdata[3*CW-1:2*CW]), want.x1);
                if ($signed(m_tdata[4*CW-1:3*CW]) !== want.y1)
                    report_mismatch("clipped_end_y", $signed(m_tdata[4*CW-1:3*CW]), want.y1);
            end
        end
        if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Register writes happen at a rising edge; only called while idle.
    task automatic write_window(longint xl, longint yl, longint xh, longint yh);
        cfg_reg_t idx[4] = '{REG_X_MIN, REG_Y_MIN, REG_X_MAX, REG_Y_MAX};
        longint   val[4];
        val = '{xl, yl, xh, yh};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i][CW-1:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_xl = longint'($signed(xl[CW-1:0]));
        win_yl = longint'($signed(yl[CW-1:0]));
        win_xh = longint'($signed(xh[CW-1:0]));
        win_yh = longint'($signed(yh[CW-1:0]));
    endtask

    // Waits until every segment has gone in and every result has come out,
    // then lets the longest pipeline latency pass as well.
    task automatic drain_clipper();
        while (pending_segments.size() > 0 || s_tvalid || expected_clips.size() > 0)
            @(posedge aclk);
        repeat (160) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] any_coord();
        return CW'($urandom());
    endfunction

    // Coordinates that mostly fall around the window, so clipping is exercised.
    function automatic logic [CW-1:0] near_coord(longint lo, longint hi);
        longint span, v;
        if ($urandom_range(9) == 0) return any_coord();
        if (lo > hi) begin v = lo; lo = hi; hi = v; end
        span = hi - lo + 1;
        v = lo - span / 2 + longint'($urandom_range(32'(2 * span)));
        if ($urandom_range(7) == 0) v = ($urandom_range(1)) ? lo : hi;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[CW-1:0];
    endfunction

    task automatic queue_segment(longint x0, longint y0, longint x1, longint y1);
        segment_t sg;
        sg.x0 = x0[CW-1:0]; sg.y0 = y0[CW-1:0];
        sg.x1 = x1[CW-1:0]; sg.y1 = y1[CW-1:0];
        pending_segments.push_back(sg);
    endtask

    task automatic queue_random(int count);
        repeat (count) begin
            pending_segments.push_back({near_coord(win_yl, win_yh), near_coord(win_xl, win_xh),
                                        near_coord(win_yl, win_yh), near_coord(win_xl, win_xh)});
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cases against the reset window 0..499.
        queue_segment(10, 10, 400, 300);                 // fully inside, accepted as is
        queue_segment(-100, -5, -10, -600);              // both left, trivial reject
        queue_segment(600, 700, 800, 900);               // above and right, shared bits
        queue_segment(-100, 250, 600, 250);              // crosses left and right edges
        queue_segment(250, -100, 250, 900);              // crosses below and above
        queue_segment(-50, -50, 550, 550);               // corner to corner diagonal
        queue_segment(-300, 100, 100, -300);             // misses the lower left corner
        queue_segment(0, 0, 499, 499);                   // exactly on the edges
        queue_segment(-32768, -32768, 32767, 32767);     // field extremes
        queue_segment(32767, -32768, -32768, 32767);
        queue_segment(-32768, 0, -32768, 0);             // degenerate point outside
        queue_segment(200, 200, 200, 200);               // degenerate point inside
        queue_segment(100, 600, 700, 100);               // first endpoint above only
        queue_segment(450, 300, 900, -400);              // second endpoint below and right
        drain_clipper();

        // Inverted window: codes may never settle, the stage limit applies.
        write_window(300, 300, 100, 100);
        queue_segment(200, 0, 200, 400);
        queue_segment(0, 200, 400, 200);
        queue_segment(50, 50, 350, 350);
        queue_segment(-32768, 32767, 32767, -32768);
        queue_random(60);
        drain_clipper();

        // Extreme window, then a negative one, with light sender gaps and a
        // busy receiver.
        sender_idle_pct = 7; receiver_idle_pct = 52;
        write_window(-32768, -32768, 32767, 32767);
        queue_random(200);
        drain_clipper();
        write_window(-1000, -200, -10, 3000);
        queue_random(450);
        // The receiver stalls long enough for the row to fill and s_tready to drop.
        @(posedge aclk);
        hold_off_go = 1'b1;
        drain_clipper();

        // Roles swapped.
        sender_idle_pct = 52; receiver_idle_pct = 7;
        write_window(-40, -40, 40, 40);
        queue_random(450);
        drain_clipper();
        write_window(32000, -32768, 32767, -32000);
        queue_random(200);
        drain_clipper();

        // Full rate both sides, back to the reset window.
        sender_idle_pct = 0; receiver_idle_pct = 0;
        write_window(0, 0, 499, 499);
        queue_random(560);
        drain_clipper();

        if (mismatch_count == 0 && expected_clips.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
